// ----- sv/ocg_pkg.sv -----
// Shared types and constants for the dual motor overcurrent guard.
// Holds the configuration and state records and the sequence phase codes.
// No dependencies.
package ocg_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_LIMIT_A   = 3'd0;
  localparam logic [2:0] CFG_LIMIT_B   = 3'd1;
  localparam logic [2:0] CFG_TRIP      = 3'd2;
  localparam logic [2:0] CFG_RELEASE   = 3'd3;
  localparam logic [2:0] CFG_FORWARD   = 3'd4;
  localparam logic [2:0] CFG_TURN      = 3'd5;
  localparam logic [2:0] CFG_PAUSE     = 3'd6;
  localparam logic [2:0] CFG_BLINK     = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Reset values of the configuration registers
  localparam logic [11:0] LIMIT_RST   = 12'd507;
  localparam logic [15:0] TRIP_RST    = 16'd50;
  localparam logic [15:0] RELEASE_RST = 16'd1000;
  localparam logic [15:0] FORWARD_RST = 16'd820;
  localparam logic [15:0] TURN_RST    = 16'd1000;
  localparam logic [15:0] PAUSE_RST   = 16'd200;
  localparam logic [9:0]  BLINK_RST   = 10'd250;

  // Extra hold ticks the button counter may run past the release length
  localparam logic [16:0] HOLD_MARGIN = 17'd200;

  // Duty percentages of the drive sequence
  localparam int PCT_FORWARD = 50;
  localparam int PCT_TURN    = 55;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FWD    = 3'd1,
    PH_PAUSE1 = 3'd2,
    PH_TURN   = 3'd3,
    PH_PAUSE2 = 3'd4,
    PH_DONE   = 3'd5
  } ocg_phase_t;

  typedef struct packed {
    logic [11:0] limit_a;
    logic [11:0] limit_b;
    logic [15:0] trip_ticks;
    logic [15:0] release_ticks;
    logic [15:0] forward_ticks;
    logic [15:0] turn_ticks;
    logic [15:0] pause_ticks;
    logic [9:0]  blink_ticks;
  } ocg_cfg_t;

  typedef struct packed {
    logic        fault;
    logic [15:0] over_a;
    logic [15:0] over_b;
    logic [16:0] hold;
    logic [31:0] faults;
    logic [8:0]  duty_a;
    logic [8:0]  duty_b;
    ocg_phase_t  phase;
    logic [15:0] timer;
    logic [9:0]  blink;
    logic        led;
    logic        pwm;
    logic        b_rev;
  } ocg_state_t;

endpackage

// ----- sv/ocg_cfg_regs.sv -----
// Configuration register file of the overcurrent guard.
// Depends on ocg_pkg for the register record, indexes and reset values.
module ocg_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ocg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ocg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ocg_pkg::ocg_cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit_a       <= ocg_pkg::LIMIT_RST;
      cfg.limit_b       <= ocg_pkg::LIMIT_RST;
      cfg.trip_ticks    <= ocg_pkg::TRIP_RST;
      cfg.release_ticks <= ocg_pkg::RELEASE_RST;
      cfg.forward_ticks <= ocg_pkg::FORWARD_RST;
      cfg.turn_ticks    <= ocg_pkg::TURN_RST;
      cfg.pause_ticks   <= ocg_pkg::PAUSE_RST;
      cfg.blink_ticks   <= ocg_pkg::BLINK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ocg_pkg::CFG_LIMIT_A: cfg.limit_a       <= cfg_data[11:0];
        ocg_pkg::CFG_LIMIT_B: cfg.limit_b       <= cfg_data[11:0];
        ocg_pkg::CFG_TRIP:    cfg.trip_ticks    <= cfg_data;
        ocg_pkg::CFG_RELEASE: cfg.release_ticks <= cfg_data;
        ocg_pkg::CFG_FORWARD: cfg.forward_ticks <= cfg_data;
        ocg_pkg::CFG_TURN:    cfg.turn_ticks    <= cfg_data;
        ocg_pkg::CFG_PAUSE:   cfg.pause_ticks   <= cfg_data;
        ocg_pkg::CFG_BLINK:   cfg.blink_ticks   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/ocg_step.sv -----
// Per-tick next-state logic of the overcurrent guard: persistence counters,
// fault latch and clear, drive sequence and heartbeat. Purely combinational.
// Depends on ocg_pkg for the state and configuration records.
module ocg_step #(
  parameter int PWM_PERIOD = 421
) (
  input  ocg_pkg::ocg_cfg_t   cfg,
  input  ocg_pkg::ocg_state_t cur,
  input  logic [11:0]         sample_a,
  input  logic [11:0]         sample_b,
  input  logic                button_pressed,
  output ocg_pkg::ocg_state_t nxt
);

  localparam logic [8:0] DUTY_FWD  = 9'((PWM_PERIOD * ocg_pkg::PCT_FORWARD) / 100);
  localparam logic [8:0] DUTY_TURN = 9'((PWM_PERIOD * ocg_pkg::PCT_TURN) / 100);

  logic [15:0] over_a;
  logic [15:0] over_b;
  logic        trip;
  logic [16:0] timer_inc;
  logic [15:0] phase_len;
  logic        phase_end;
  logic [16:0] hold_cap;
  logic [16:0] hold_inc;
  logic [10:0] blink_inc;

  always_comb begin
    over_a = (sample_a > cfg.limit_a) ?
             ((cur.over_a == 16'hFFFF) ? 16'hFFFF : cur.over_a + 16'd1) : 16'd0;
    over_b = (sample_b > cfg.limit_b) ?
             ((cur.over_b == 16'hFFFF) ? 16'hFFFF : cur.over_b + 16'd1) : 16'd0;
    trip   = (over_a >= cfg.trip_ticks) || (over_b >= cfg.trip_ticks);

    case (cur.phase)
      ocg_pkg::PH_FWD:    phase_len = cfg.forward_ticks;
      ocg_pkg::PH_TURN:   phase_len = cfg.turn_ticks;
      default:            phase_len = cfg.pause_ticks;
    endcase
    timer_inc = {1'b0, cur.timer} + 17'd1;
    phase_end = timer_inc >= {1'b0, phase_len};

    hold_cap = {1'b0, cfg.release_ticks} + ocg_pkg::HOLD_MARGIN;
    hold_inc = (cur.hold < hold_cap) ? cur.hold + 17'd1 : cur.hold;

    nxt        = cur;
    nxt.over_a = over_a;
    nxt.over_b = over_b;

    if (!cur.fault) begin
      if (trip) begin
        nxt.fault  = 1'b1;
        nxt.pwm    = 1'b0;
        nxt.led    = 1'b1;
        nxt.faults = cur.faults + 32'd1;
      end else begin
        // Advance the drive sequence; the timer moves only in timed phases
        case (cur.phase)
          ocg_pkg::PH_FWD: begin
            nxt.b_rev  = 1'b0;
            nxt.duty_a = DUTY_FWD;
            nxt.duty_b = DUTY_FWD;
            if (phase_end) begin
              nxt.phase  = ocg_pkg::PH_PAUSE1;
              nxt.duty_a = '0;
              nxt.duty_b = '0;
            end
          end
          ocg_pkg::PH_PAUSE1: begin
            if (phase_end) begin
              nxt.phase  = ocg_pkg::PH_TURN;
              nxt.b_rev  = 1'b1;
              nxt.duty_a = DUTY_TURN;
              nxt.duty_b = DUTY_TURN;
            end
          end
          ocg_pkg::PH_TURN: begin
            if (phase_end) begin
              nxt.phase  = ocg_pkg::PH_PAUSE2;
              nxt.duty_a = '0;
              nxt.duty_b = '0;
            end
          end
          ocg_pkg::PH_PAUSE2: begin
            if (phase_end) begin
              nxt.phase = ocg_pkg::PH_DONE;
            end
          end
          default: ;
        endcase
        if (cur.phase inside {ocg_pkg::PH_FWD, ocg_pkg::PH_PAUSE1,
                              ocg_pkg::PH_TURN, ocg_pkg::PH_PAUSE2}) begin
          nxt.timer = phase_end ? 16'd0 : timer_inc[15:0];
        end
      end
    end else if (button_pressed) begin
      nxt.hold = hold_inc;
      if (hold_inc >= {1'b0, cfg.release_ticks}) begin
        nxt.fault  = 1'b0;
        nxt.over_a = '0;
        nxt.over_b = '0;
        nxt.hold   = '0;
        nxt.led    = 1'b0;
        nxt.pwm    = 1'b1;
      end
    end else begin
      nxt.hold = '0;
    end

    // Heartbeat runs whenever healthy after this tick, including the clear tick
    blink_inc = {1'b0, nxt.blink} + 11'd1;
    if (!nxt.fault) begin
      if (blink_inc >= {1'b0, cfg.blink_ticks}) begin
        nxt.blink = '0;
        nxt.led   = ~nxt.led;
      end else begin
        nxt.blink = blink_inc[9:0];
      end
    end
  end

endmodule

// ----- sv/dual_motor_overcurrent_guard.sv -----
// Top level of the dual motor overcurrent guard: handshakes, tick register,
// guard state register and the end-of-file assertions.
// Depends on ocg_pkg, ocg_cfg_regs and ocg_step.
//
//   channel   direction  handshake              payload
//   tick in   input      in_valid / in_ready    sample_a, sample_b, button_pressed
//   result    output     out_valid / out_ready  faulted .. fault_total
//   config    input      cfg_we (no wait)       cfg_index, cfg_data
//
// One tick per clock cycle sustained while results are taken; each tick passes
// the input register, then the guard state register, and appears as a result.
// The guard state register is the result register: its outputs are the state
// after the last tick, and it only advances when the result slot is free.
// A stalled result holds the state; the input register still takes one more tick.
// Reset is synchronous and restores config defaults and all but the tick payload.
module dual_motor_overcurrent_guard #(
  parameter int PWM_PERIOD = 421
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [11:0]                     sample_a,
  input  logic [11:0]                     sample_b,
  input  logic                            button_pressed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            faulted,
  output logic                            led_on,
  output logic                            drive_enable,
  output logic [8:0]                      duty_a,
  output logic [8:0]                      duty_b,
  output logic                            b_reverse,
  output logic [2:0]                      phase,
  output logic [31:0]                     fault_total,
  input  logic                            cfg_we,
  input  logic [ocg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ocg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [8:0] DUTY_RST = 9'((PWM_PERIOD * ocg_pkg::PCT_FORWARD) / 100);

  ocg_pkg::ocg_cfg_t   cfg;
  ocg_pkg::ocg_state_t state;
  ocg_pkg::ocg_state_t state_next;

  // Input register
  logic        tick_valid;
  logic [11:0] tick_a;
  logic [11:0] tick_b;
  logic        tick_btn;
  logic        advance;

  ocg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ocg_step #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_step (
    .cfg            (cfg),
    .cur            (state),
    .sample_a       (tick_a),
    .sample_b       (tick_b),
    .button_pressed (tick_btn),
    .nxt            (state_next)
  );

  // Advance a held tick into the state whenever the result slot is free
  assign advance  = tick_valid && (!out_valid || out_ready);
  assign in_ready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      tick_valid <= 1'b1;
    end else if (advance) begin
      tick_valid <= 1'b0;
    end
  end

  // Payload only: no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick_a   <= sample_a;
      tick_b   <= sample_b;
      tick_btn <= button_pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.fault  <= 1'b0;
      state.over_a <= '0;
      state.over_b <= '0;
      state.hold   <= '0;
      state.faults <= '0;
      state.duty_a <= DUTY_RST;
      state.duty_b <= DUTY_RST;
      state.phase  <= ocg_pkg::PH_FWD;
      state.timer  <= '0;
      state.blink  <= '0;
      state.led    <= 1'b0;
      state.pwm    <= 1'b1;
      state.b_rev  <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  assign faulted      = state.fault;
  assign led_on       = state.led;
  assign drive_enable = state.pwm;
  assign duty_a       = state.duty_a;
  assign duty_b       = state.duty_b;
  assign b_reverse    = state.b_rev;
  assign phase        = state.phase;
  assign fault_total  = state.faults;

`ifndef ASSERT_OFF
  // A latched fault always drops drive and lights the LED
  a_fault_outputs: assert property (@(posedge clk) disable iff (rst)
    faulted |-> (!drive_enable && led_on))
    else $error("fault latched without drive off and LED on");

  // Entering a fault counts exactly one fault
  a_fault_count: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(faulted)) |-> (fault_total == $past(fault_total) + 32'd1))
    else $error("fault total did not count a new fault");

  // The sequence only ever steps forward one phase at a time
  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (phase != $past(phase))) |-> (phase == $past(phase) + 3'd1))
    else $error("sequence phase skipped or went back");

  // No new tick reaches the state while a result waits
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(fault_total) && $stable(phase))
    else $error("state advanced under a stalled result");
`endif

endmodule
